// ----- sv/esa_pkg.sv -----
package esa_pkg;

  // field widths of the stream payloads
  localparam int MODE_W      = 3;
  localparam int ID_W        = 6;
  localparam int COMP_W      = 5;
  localparam int QUERY_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // input tdata layout
  localparam int IN_ID_LSB    = 0;
  localparam int IN_COMP_LSB  = IN_ID_LSB + ID_W;
  localparam int IN_QUERY_LSB = IN_COMP_LSB + COMP_W;

  // operation codes (tuser)
  localparam logic [MODE_W-1:0] OP_CREATE = 3'd0;
  localparam logic [MODE_W-1:0] OP_DELETE = 3'd1;
  localparam logic [MODE_W-1:0] OP_SET    = 3'd2;
  localparam logic [MODE_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [MODE_W-1:0] OP_TEST   = 3'd4;
  localparam logic [MODE_W-1:0] OP_FILTER = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ENTITY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  op;
    logic [ID_W-1:0]    id;
    logic [COMP_W-1:0]  comp;
    logic [QUERY_W-1:0] query;
  } cmd_t;

endpackage

// ----- sv/esa_ram.sv -----
module esa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/esa_front.sv -----
module esa_front import esa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [MODE_W-1:0]     s_axis_tuser,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  // two-entry command queue
  cmd_t       q [2];
  logic       wptr, rptr;
  logic [1:0] cnt;

  cmd_t cmd_in;
  logic acc, keep, pop;

  always_comb begin
    cmd_in.op    = s_axis_tuser;
    cmd_in.id    = s_axis_tdata[IN_ID_LSB +: ID_W];
    cmd_in.comp  = s_axis_tdata[IN_COMP_LSB +: COMP_W];
    cmd_in.query = s_axis_tdata[IN_QUERY_LSB +: QUERY_W];
  end

  assign s_axis_tready = (cnt != 2'd2);
  assign acc           = s_axis_tvalid && s_axis_tready;
  // unused opcodes are swallowed here and never reach the back end
  assign keep          = acc && (s_axis_tuser <= OP_FILTER);
  assign cmd_valid     = (cnt != 2'd0);
  assign cmd           = q[rptr];
  assign pop           = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (keep) begin
      q[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (keep) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(keep) - 2'(pop);
    end
  end

endmodule

// ----- sv/esa_back.sv -----
module esa_back import esa_pkg::*; #(
  parameter int MAX_ENTITIES = 64,
  parameter int SIG_BITS     = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_t                   cmd,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int IDX_W = $clog2(MAX_ENTITIES);
  localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
  localparam int CMP_W = ID_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]              state, state_next;
  logic [CNT_W-1:0]        slots_used, slots_used_next;
  logic [CNT_W-1:0]        free_count, free_count_next;
  logic [MAX_ENTITIES-1:0] deleted, deleted_next;
  logic [IDX_W-1:0]        ptr, ptr_next;
  logic [IDX_W-1:0]        pend_id, pend_id_next;
  logic                    pend_vld, pend_vld_next;
  cmd_t                    cur, cur_next;

  logic                out_vld, out_vld_next;
  logic [ID_W-1:0]     out_id, out_id_next;
  logic [STATUS_W-1:0] out_st, out_st_next;
  logic                out_bit, out_bit_next;
  logic                out_last, out_last_next;

  logic                sig_we, sig_re;
  logic [IDX_W-1:0]    sig_waddr, sig_raddr;
  logic [SIG_BITS-1:0] sig_wdata, sig_rdata;
  logic                stk_we, stk_re;
  logic [IDX_W-1:0]    stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  esa_ram #(.WIDTH(SIG_BITS), .DEPTH(MAX_ENTITIES)) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (sig_waddr),
    .wdata (sig_wdata),
    .re    (sig_re),
    .raddr (sig_raddr),
    .rdata (sig_rdata)
  );

  esa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTITIES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  logic                out_free, take;
  logic [CMP_W-1:0]    used_c, nxt_c;
  logic [IDX_W-1:0]    idx;
  logic                known, live, match, stall;
  logic [SIG_BITS-1:0] bitm, qmask;

  assign out_free  = !out_vld || m_axis_tready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;
  assign used_c    = CMP_W'(slots_used);
  assign idx       = cmd.id[IDX_W-1:0];
  // id below slots_used keeps idx from aliasing
  assign known     = {1'b0, cmd.id} < used_c;
  assign live      = known && (cmd.id != '0) && !deleted[idx];
  // bit indexes at or above SIG_BITS shift out to an empty mask
  assign bitm      = SIG_BITS'(1) << cur.comp;
  assign qmask     = SIG_BITS'(cur.query);
  assign match     = !deleted[ptr] && ((sig_rdata & qmask) == qmask);
  assign stall     = match && pend_vld && !out_free;
  assign nxt_c     = CMP_W'(ptr) + CMP_W'(1);

  always_comb begin
    state_next      = state;
    slots_used_next = slots_used;
    free_count_next = free_count;
    deleted_next    = deleted;
    ptr_next        = ptr;
    pend_id_next    = pend_id;
    pend_vld_next   = pend_vld;
    cur_next        = cur;
    out_vld_next    = out_vld && !m_axis_tready;
    out_id_next     = out_id;
    out_st_next     = out_st;
    out_bit_next    = out_bit;
    out_last_next   = out_last;
    sig_we          = 1'b0;
    sig_waddr       = '0;
    sig_wdata       = '0;
    sig_re          = 1'b0;
    sig_raddr       = '0;
    stk_we          = 1'b0;
    stk_waddr       = IDX_W'(free_count);
    stk_wdata       = idx;
    stk_re          = 1'b0;
    stk_raddr       = IDX_W'(free_count - CNT_W'(1));

    unique case (state)
      S_IDLE: begin
        if (take) begin
          cur_next      = cmd;
          out_bit_next  = 1'b0;
          out_last_next = 1'b1;
          out_id_next   = cmd.id;
          case (cmd.op) inside
            OP_CREATE: begin
              if (free_count != '0) begin
                stk_re          = 1'b1;
                free_count_next = free_count - CNT_W'(1);
                state_next      = S_POP;
              end else if (slots_used < CNT_W'(MAX_ENTITIES)) begin
                slots_used_next = slots_used + CNT_W'(1);
                deleted_next[IDX_W'(slots_used)] = 1'b0;
                sig_we       = 1'b1;
                sig_waddr    = IDX_W'(slots_used);
                out_vld_next = 1'b1;
                out_id_next  = ID_W'(slots_used);
                out_st_next  = ST_OK;
              end else begin
                out_vld_next = 1'b1;
                out_id_next  = '0;
                out_st_next  = ST_FULL;
              end
            end
            OP_DELETE: begin
              out_vld_next = 1'b1;
              if (!known) begin
                out_st_next = ST_NO_ENTITY;
              end else if (deleted[idx]) begin
                out_st_next = ST_DELETED;
              end else begin
                deleted_next[idx] = 1'b1;
                stk_we            = 1'b1;
                free_count_next   = free_count + CNT_W'(1);
                out_st_next       = ST_OK;
              end
            end
            OP_SET, OP_CLEAR, OP_TEST: begin
              if (!live) begin
                out_vld_next = 1'b1;
                out_st_next  = ST_NO_ENTITY;
              end else begin
                sig_re     = 1'b1;
                sig_raddr  = idx;
                state_next = S_RMW;
              end
            end
            OP_FILTER: begin
              if (slots_used <= CNT_W'(1)) begin
                out_vld_next = 1'b1;
                out_id_next  = '0;
                out_st_next  = ST_NO_MATCH;
              end else begin
                sig_re        = 1'b1;
                sig_raddr     = IDX_W'(1);
                ptr_next      = IDX_W'(1);
                pend_vld_next = 1'b0;
                state_next    = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        // output register is empty here: it was free when the command started
        deleted_next[stk_rdata] = 1'b0;
        sig_we        = 1'b1;
        sig_waddr     = stk_rdata;
        out_vld_next  = 1'b1;
        out_id_next   = ID_W'(stk_rdata);
        out_st_next   = ST_OK;
        state_next    = S_IDLE;
      end
      S_RMW: begin
        sig_we       = (cur.op != OP_TEST);
        sig_waddr    = cur.id[IDX_W-1:0];
        sig_wdata    = (cur.op == OP_SET) ? (sig_rdata | bitm) : (sig_rdata & ~bitm);
        out_vld_next = 1'b1;
        out_st_next  = ST_OK;
        out_bit_next = (cur.op == OP_TEST) && |(sig_rdata & bitm);
        state_next   = S_IDLE;
      end
      S_SCAN: begin
        // one slot per cycle unless a held match meets a busy output; a match is held
        // back until the next one or the end of the scan shows whether it is the last
        if (!stall) begin
          if (match) begin
            if (pend_vld) begin
              out_vld_next  = 1'b1;
              out_id_next   = ID_W'(pend_id);
              out_st_next   = ST_OK;
              out_bit_next  = 1'b0;
              out_last_next = 1'b0;
            end
            pend_id_next  = ptr;
            pend_vld_next = 1'b1;
          end
          if (nxt_c < used_c) begin
            ptr_next  = IDX_W'(nxt_c);
            sig_re    = 1'b1;
            sig_raddr = IDX_W'(nxt_c);
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_next  = 1'b1;
          out_bit_next  = 1'b0;
          out_last_next = 1'b1;
          out_id_next   = pend_vld ? ID_W'(pend_id) : '0;
          out_st_next   = pend_vld ? ST_OK : ST_NO_MATCH;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slots_used <= CNT_W'(1);
      free_count <= '0;
      deleted    <= MAX_ENTITIES'(1);
      pend_vld   <= 1'b0;
      out_vld    <= 1'b0;
    end else begin
      state      <= state_next;
      slots_used <= slots_used_next;
      free_count <= free_count_next;
      deleted    <= deleted_next;
      pend_vld   <= pend_vld_next;
      out_vld    <= out_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    pend_id  <= pend_id_next;
    cur      <= cur_next;
    out_id   <= out_id_next;
    out_st   <= out_st_next;
    out_bit  <= out_bit_next;
    out_last <= out_last_next;
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = OUT_TDATA_W'({out_bit, out_st, out_id});

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    slots_used >= CNT_W'(1) && slots_used <= CNT_W'(MAX_ENTITIES))
    else $error("slots_used out of range");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    free_count < slots_used)
    else $error("free stack deeper than handed-out slots");

  a_reserved: assert property (@(posedge clk) disable iff (rst)
    deleted[0])
    else $error("reserved slot became live");

  a_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP || state == S_RMW) |-> !out_vld)
    else $error("result register busy during single-result op");

endmodule

// ----- sv/entity_slot_allocator_with_signatures.sv -----
// Entity slot allocator with component signatures. Hands out ids from a
// table of MAX_ENTITIES slots (slot 0 reserved), recycling deleted ids
// most-recent-first, and keeps a SIG_BITS-wide component signature per
// entity. Opcode on s_axis_tuser: create, delete, set/clear/test a signature
// bit, filter by mask. Every op returns one result transaction except filter,
// which returns one per matching live entity in ascending id order (or a
// single no-match result); tlast marks the final result of each op. Opcodes
// 6 and 7 are dropped without a result. A two-entry command queue
// decouples the input from the execution engine. Create (fresh slot), delete
// and any error result go straight to the result register in the engine;
// create from the free stack and bit ops first do one registered read of the
// stack or signature RAM. Filter walks the signature RAM one slot per cycle,
// pausing while a held match waits on a busy output side. No clearing pass
// after reset: signatures are only read for slots that create has handed
// out, and create writes a zero signature.
module entity_slot_allocator_with_signatures import esa_pkg::*; #(
  parameter int MAX_ENTITIES = 64,
  parameter int SIG_BITS     = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [5:0] entity_id, [10:6] component_type, [42:11] query_mask, [47:43] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] mode
  input  logic [MODE_W-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [5:0] result_id, [8:6] status, [9] bit_value, [15:10] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // front: accept, decode, drop unused opcodes, queue
  esa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  // back: slot bookkeeping, signature RAM, free stack, result register
  esa_back #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .SIG_BITS     (SIG_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
